### sv/hashed_value_noise_fbm_core_assert.svh
// Assertion macros shared by the checker of the fractal noise core.
// Needs nothing but a clock and an active-low reset in the using scope.
`ifndef HASHED_VALUE_NOISE_FBM_CORE_ASSERT_SVH
`define HASHED_VALUE_NOISE_FBM_CORE_ASSERT_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define HVN_ASSERT_CR(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Same, on the usual clk_i / rst_ni pair.
`define HVN_ASSERT(lbl, prop) `HVN_ASSERT_CR(lbl, clk_i, rst_ni, prop)

`endif

### sv/hvn_pkg.sv
// Package of the fractal value noise core: constants, config codes, types.
// Used by every RTL file of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hvn_pkg;

  localparam int unsigned MAX_OCTAVES_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned QUOT_BITS       = 16;

  localparam logic [31:0] HASH_KX     = 32'd374761393;
  localparam logic [31:0] HASH_KY     = 32'd668265263;
  localparam logic [31:0] MIX_K1      = 32'h7feb352d;
  localparam logic [31:0] MIX_K2      = 32'h846ca68b;
  localparam logic [63:0] OCTAVE_SALT = 64'h9E3779B97F4A7C15;
  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [16:0] PERS_MIN    = 17'd3277;
  localparam logic [17:0] SMOOTH_K    = 18'd196608;

  localparam logic [63:0] SEED_RST = 64'd0;
  localparam logic [4:0]  OCT_RST  = 5'd4;
  localparam logic [16:0] PERS_RST = 17'd32768;

  typedef enum logic [1:0] {
    CFG_SEED = 2'd0,
    CFG_OCT  = 2'd1,
    CFG_PERS = 2'd2
  } cfg_idx_e;

  // Clamped configuration seen by every octave cell.
  typedef struct packed {
    logic [16:0] pers;
    logic [5:0]  oct;
  } cell_cfg_t;

endpackage

`default_nettype wire

### sv/hashed_value_noise_fbm_core.sv
// Throughput: one item per cycle; one octave cell per octave, eight stages deep,
// then one division cell per quotient bit. The whole row holds while a result waits.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the register
// defaults: seed 0, four octaves, persistence one half.
`timescale 1ns / 1ps
`default_nettype none

module hashed_value_noise_fbm_core #(
  parameter int unsigned MAX_OCTAVES = hvn_pkg::MAX_OCTAVES_DEF,
  parameter int unsigned FRAC_BITS   = hvn_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // x_coord [31:0], y_coord [63:32]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // noise_value [15:0]
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [63:0] cfg_wdata_i
);
  import hvn_pkg::*;

  localparam int unsigned LW = $clog2(MAX_OCTAVES);
  localparam int unsigned CW = FRAC_BITS + 32;
  localparam int unsigned SW = 49 + LW;
  localparam int unsigned TW = 17 + LW;

  logic [63:0] seed_q;
  logic [4:0]  oct_q;
  logic [16:0] pers_q;
  cell_cfg_t   cell_cfg;
  logic        en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_RST;
      oct_q  <= OCT_RST;
      pers_q <= PERS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_SEED: seed_q <= cfg_wdata_i;
        CFG_OCT:  oct_q  <= cfg_wdata_i[4:0];
        CFG_PERS: pers_q <= cfg_wdata_i[16:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    if (oct_q == 5'd0) begin
      cell_cfg.oct = 6'd1;
    end else if ({1'b0, oct_q} > 6'(MAX_OCTAVES)) begin
      cell_cfg.oct = 6'(MAX_OCTAVES);
    end else begin
      cell_cfg.oct = {1'b0, oct_q};
    end
    if (pers_q < PERS_MIN) begin
      cell_cfg.pers = PERS_MIN;
    end else if (pers_q > ONE_Q16) begin
      cell_cfg.pers = ONE_Q16;
    end else begin
      cell_cfg.pers = pers_q;
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic          vo   [MAX_OCTAVES+1];
  logic [CW-1:0] cx   [MAX_OCTAVES+1];
  logic [CW-1:0] cy   [MAX_OCTAVES+1];
  logic [63:0]   sd   [MAX_OCTAVES+1];
  logic [16:0]   amp  [MAX_OCTAVES+1];
  logic [SW-1:0] sum  [MAX_OCTAVES+1];
  logic [TW-1:0] tot  [MAX_OCTAVES+1];

  assign vo[0]  = s_axis_tvalid && en;
  assign cx[0]  = {{(CW-32){s_axis_tdata[31]}}, s_axis_tdata[31:0]};
  assign cy[0]  = {{(CW-32){s_axis_tdata[63]}}, s_axis_tdata[63:32]};
  assign sd[0]  = seed_q;
  assign amp[0] = ONE_Q16;
  assign sum[0] = '0;
  assign tot[0] = '0;

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
    hvn_octave_cell #(
      .K(k), .FracBits(FRAC_BITS), .CW(CW), .SW(SW), .TW(TW)
    ) u_cell (
      .clk_i, .rst_ni, .en_i(en), .cfg_i(cell_cfg),
      .valid_i(vo[k]), .cx_i(cx[k]), .cy_i(cy[k]), .seed_i(sd[k]),
      .amp_i(amp[k]), .sum_i(sum[k]), .total_i(tot[k]),
      .valid_o(vo[k+1]), .cx_o(cx[k+1]), .cy_o(cy[k+1]), .seed_o(sd[k+1]),
      .amp_o(amp[k+1]), .sum_o(sum[k+1]), .total_o(tot[k+1])
    );
  end

  logic                 dv [QUOT_BITS+1];
  logic [SW-1:0]        dr [QUOT_BITS+1];
  logic [TW-1:0]        dd [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] dq [QUOT_BITS+1];

  assign dv[0] = vo[MAX_OCTAVES];
  assign dr[0] = sum[MAX_OCTAVES];
  assign dd[0] = tot[MAX_OCTAVES];
  assign dq[0] = '0;

  // The quotient stays below 2^16 since every corner value is below one.
  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_div
    hvn_div_cell #(.B(QUOT_BITS - 1 - i), .SW(SW), .TW(TW)) u_div (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(dv[i]), .rem_i(dr[i]), .den_i(dd[i]), .quo_i(dq[i]),
      .valid_o(dv[i+1]), .rem_o(dr[i+1]), .den_o(dd[i+1]), .quo_o(dq[i+1])
    );
  end

  assign m_axis_tvalid = dv[QUOT_BITS];
  assign m_axis_tdata  = dq[QUOT_BITS];

endmodule

`default_nettype wire

### sv/hvn_octave_cell.sv
// One octave cell: hashes the four lattice corners, blends them and, if the octave is active, adds
// the weighted value to the running sums, over eight pipeline stages. Uses hvn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hvn_octave_cell #(
  parameter int unsigned K        = 0,
  parameter int unsigned FracBits = 16,
  parameter int unsigned CW       = 48,
  parameter int unsigned SW       = 53,
  parameter int unsigned TW       = 21
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire hvn_pkg::cell_cfg_t  cfg_i,
  input  wire logic                valid_i,
  input  wire logic [CW-1:0]       cx_i,
  input  wire logic [CW-1:0]       cy_i,
  input  wire logic [63:0]         seed_i,
  input  wire logic [16:0]         amp_i,
  input  wire logic [SW-1:0]       sum_i,
  input  wire logic [TW-1:0]       total_i,
  output logic                     valid_o,
  output logic [CW-1:0]            cx_o,
  output logic [CW-1:0]            cy_o,
  output logic [63:0]              seed_o,
  output logic [16:0]              amp_o,
  output logic [SW-1:0]            sum_o,
  output logic [TW-1:0]            total_o
);
  import hvn_pkg::*;

  localparam int unsigned NC = 7;

  logic [NC-1:0]   vld_q;
  logic [CW-1:0]   cx_q   [NC];
  logic [CW-1:0]   cy_q   [NC];
  logic [63:0]     seed_q [NC];
  logic [16:0]     amp_q  [NC];
  logic [SW-1:0]   sum_q  [NC];
  logic [TW-1:0]   tot_q  [NC];

  logic [15:0] tx, ty;
  logic [31:0] ix, iy;

  generate
    if (FracBits >= 16) begin : g_frac_dn
      assign tx = cx_i[FracBits-1 -: 16];
      assign ty = cy_i[FracBits-1 -: 16];
    end else begin : g_frac_up
      assign tx = {cx_i[FracBits-1:0], {(16-FracBits){1'b0}}};
      assign ty = {cy_i[FracBits-1:0], {(16-FracBits){1'b0}}};
    end
  endgenerate

  assign ix = cx_i[FracBits +: 32];
  assign iy = cy_i[FracBits +: 32];

  // Stage 1 registers.
  logic [31:0] mx_q, my_q, fold_q, ttx_q, tty_q;
  logic [15:0] tx_q, ty_q;
  // Stage 2 to 7 registers.
  logic [31:0] ha_q [4];
  logic [15:0] sx_q, sy_q, sx3_q, sy3_q, sx4_q, sy4_q, sy5_q;
  logic [31:0] hb_q [4];
  logic [31:0] hc_q [4];
  logic [48:0] pl_q [4];
  logic [48:0] pm_q [2];
  logic [31:0] v_q;

  logic [31:0] ha_d [4];
  logic [31:0] hb_x [4];
  logic [31:0] n_x  [4];
  logic [47:0] spx, spy;
  logic [49:0] r0_s, r1_s, v_s;
  logic        active;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      ha_d[j] = fold_q + mx_q + my_q + ((j % 2 == 1) ? HASH_KX : 32'd0)
              + ((j / 2 == 1) ? HASH_KY : 32'd0);
      ha_d[j] = ha_d[j] ^ (ha_d[j] >> 16);
      hb_x[j] = hb_q[j] ^ (hb_q[j] >> 15);
      n_x[j]  = hc_q[j] ^ (hc_q[j] >> 16);
    end
    spx  = 48'(ttx_q) * 48'(SMOOTH_K - {1'b0, tx_q, 1'b0});
    spy  = 48'(tty_q) * 48'(SMOOTH_K - {1'b0, ty_q, 1'b0});
    r0_s = 50'(pl_q[0]) + 50'(pl_q[1]);
    r1_s = 50'(pl_q[2]) + 50'(pl_q[3]);
    v_s  = 50'(pm_q[0]) + 50'(pm_q[1]);
  end

  assign active = (6'(K) < cfg_i.oct);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      vld_q   <= {vld_q[NC-2:0], valid_i};
      valid_o <= vld_q[NC-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q[0] <= cx_i;  cy_q[0] <= cy_i;  seed_q[0] <= seed_i;
      amp_q[0] <= amp_i; sum_q[0] <= sum_i; tot_q[0] <= total_i;
      for (int i = 1; i < NC; i++) begin
        cx_q[i] <= cx_q[i-1];  cy_q[i] <= cy_q[i-1];  seed_q[i] <= seed_q[i-1];
        amp_q[i] <= amp_q[i-1]; sum_q[i] <= sum_q[i-1]; tot_q[i] <= tot_q[i-1];
      end
      // Stage 1: lattice products, squared fractions, folded seed.
      mx_q   <= ix * HASH_KX;
      my_q   <= iy * HASH_KY;
      fold_q <= seed_i[31:0] ^ seed_i[63:32];
      tx_q   <= tx;
      ty_q   <= ty;
      ttx_q  <= 32'(tx) * 32'(tx);
      tty_q  <= 32'(ty) * 32'(ty);
      // Stage 2: corner hashes start, smoothstep weights finish.
      sx_q <= spx[47:32];
      sy_q <= spy[47:32];
      for (int j = 0; j < 4; j++) begin
        ha_q[j] <= ha_d[j];
        hb_q[j] <= ha_q[j] * MIX_K1;
        hc_q[j] <= hb_x[j] * MIX_K2;
        pl_q[j] <= (j % 2 == 1) ? 49'(n_x[j]) * 49'(sx4_q)
                                : 49'(n_x[j]) * 49'(ONE_Q16 - {1'b0, sx4_q});
      end
      sx3_q <= sx_q;  sy3_q <= sy_q;
      sx4_q <= sx3_q; sy4_q <= sy3_q;
      sy5_q <= sy4_q;
      // Stage 6: row blends, then column weights; stage 7: column blend.
      pm_q[0] <= 49'(r0_s[47:16]) * 49'(ONE_Q16 - {1'b0, sy5_q});
      pm_q[1] <= 49'(r1_s[47:16]) * 49'(sy5_q);
      v_q     <= v_s[47:16];
      // Stage 8: accumulate and hand the octave on to the next cell.
      cx_o    <= {cx_q[NC-1][CW-2:0], 1'b0};
      cy_o    <= {cy_q[NC-1][CW-2:0], 1'b0};
      seed_o  <= seed_q[NC-1] + OCTAVE_SALT;
      amp_o   <= 17'((34'(amp_q[NC-1]) * 34'(cfg_i.pers)) >> 16);
      sum_o   <= active ? sum_q[NC-1] + SW'(49'(amp_q[NC-1]) * 49'(v_q))
                        : sum_q[NC-1];
      total_o <= active ? tot_q[NC-1] + TW'(amp_q[NC-1]) : tot_q[NC-1];
    end
  end

endmodule

`default_nettype wire

### sv/hvn_div_cell.sv
// One restoring-division cell: decides quotient bit B of sum / (total * 2^16).
// Uses hvn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hvn_div_cell #(
  parameter int unsigned B  = 15,
  parameter int unsigned SW = 53,
  parameter int unsigned TW = 21
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic [SW-1:0]                 rem_i,
  input  wire logic [TW-1:0]                 den_i,
  input  wire logic [hvn_pkg::QUOT_BITS-1:0] quo_i,
  output logic                               valid_o,
  output logic [SW-1:0]                      rem_o,
  output logic [TW-1:0]                      den_o,
  output logic [hvn_pkg::QUOT_BITS-1:0]      quo_o
);
  import hvn_pkg::*;

  logic [SW-1:0]        dsh;
  logic                 ge;
  logic [QUOT_BITS-1:0] quo_d;

  always_comb begin
    dsh      = SW'(den_i) << (QUOT_BITS + B);
    ge       = (rem_i >= dsh);
    quo_d    = quo_i;
    quo_d[B] = ge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= ge ? rem_i - dsh : rem_i;
      den_o <= den_i;
      quo_o <= quo_d;
    end
  end

endmodule

`default_nettype wire

### sv/hvn_checker.sv
// Port-level checker for the fractal noise core, bound to the top level.
// Depends on hashed_value_noise_fbm_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "hashed_value_noise_fbm_core_assert.svh"

module hvn_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // A stalled result item holds its value.
  `HVN_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  // With nothing waiting at the output, the block takes an item.
  `HVN_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready)
  // A result being taken frees the row for a new item in the same cycle.
  `HVN_ASSERT(a_ready_on_drain, m_axis_tready |-> s_axis_tready)
  // A blocked input means a result item is waiting.
  `HVN_ASSERT(a_stall_cause, s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)

endmodule

bind hashed_value_noise_fbm_core hvn_checker u_hvn_checker (.*);

`default_nettype wire
